// ===== rtl/uuid5_pkg.sv =====
// ---------------------------------------------------------------------------
// uuid5_pkg
// Shared types, constants and helper functions for the name-based UUID
// (SHA-1) generator: hash constants, message block constants, the
// controller/datapath command and status words and text formatting helpers.
// ---------------------------------------------------------------------------
package uuid5_pkg;

   // SHA-1 initial hash value
   localparam logic [31:0] H0 = 32'h67452301;
   localparam logic [31:0] H1 = 32'hEFCDAB89;
   localparam logic [31:0] H2 = 32'h98BADCFE;
   localparam logic [31:0] H3 = 32'h10325476;
   localparam logic [31:0] H4 = 32'hC3D2E1F0;

   // SHA-1 round constants
   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   // DNS namespace UUID as big-endian message words
   localparam logic [31:0] NS_W0 = 32'h6ba7b810;
   localparam logic [31:0] NS_W1 = 32'h9dad11d1;
   localparam logic [31:0] NS_W2 = 32'h80b400c0;
   localparam logic [31:0] NS_W3 = 32'h4fd430c8;

   // padding marker after the 28 message bytes, and 224-bit length word
   localparam logic [31:0] PAD_WORD = 32'h80000000;
   localparam logic [31:0] LEN_WORD = 32'h000000E0;

   localparam int unsigned ROUNDS    = 80;
   localparam int unsigned TEXT_LEN  = 36;
   localparam logic [6:0]  LAST_ROUND = 7'(ROUNDS - 1);
   localparam logic [5:0]  LAST_CHAR  = 6'(TEXT_LEN - 1);
   localparam logic [6:0]  DASH_CHAR  = 7'h2d;

   // version nibble and variant bits
   localparam logic [3:0]  VERSION_NIB = 4'h5;
   localparam logic [1:0]  VARIANT_BITS = 2'b10;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FINAL,
      ST_EMIT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture MAC, build block, init working regs
      logic step;     // run one compression round
      logic finish;   // add initial hash, format digest
      logic advance;  // current text word taken, move to next character
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic round_last;
      logic char_last;
   } sts_type;

   // lowercase hex digit
   function automatic logic [6:0] nib_char(input logic [3:0] n);
      if (n < 4'd10) begin
         return 7'h30 + 7'(n);
      end else begin
         return 7'h57 + 7'(n);
      end
   endfunction

   // four hex characters of a 16-bit value, packed as big-endian bytes
   function automatic logic [31:0] hex_word(input logic [15:0] v);
      return {1'b0, nib_char(v[15:12]), 1'b0, nib_char(v[11:8]),
              1'b0, nib_char(v[7:4]),   1'b0, nib_char(v[3:0])};
   endfunction

   // text position holds a dash between groups
   function automatic logic is_dash(input logic [5:0] pos);
      return (pos == 6'd8) || (pos == 6'd13) || (pos == 6'd18) || (pos == 6'd23);
   endfunction

   // digest nibble shown at a text position (dashes skipped)
   function automatic logic [4:0] pos_nibble(input logic [5:0] pos);
      logic [5:0] idx;
      if (pos < 6'd8) begin
         idx = pos;
      end else if (pos < 6'd13) begin
         idx = pos - 6'd1;
      end else if (pos < 6'd18) begin
         idx = pos - 6'd2;
      end else if (pos < 6'd23) begin
         idx = pos - 6'd3;
      end else begin
         idx = pos - 6'd4;
      end
      return idx[4:0];
   endfunction

endpackage

// ===== rtl/uuid5_ctrl.sv =====
// ---------------------------------------------------------------------------
// uuid5_ctrl
// Sequencer for the UUID generator: accepts a word, steps the hash rounds,
// finalizes the digest and hands out the text characters.
// ---------------------------------------------------------------------------
module uuid5_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  uuid5_pkg::sts_type sts,
   output uuid5_pkg::cmd_type cmd
);

   uuid5_pkg::state_type state_ff;
   uuid5_pkg::state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         uuid5_pkg::ST_IDLE: begin
            if (req_valid) state_in = uuid5_pkg::ST_ROUND;
         end
         uuid5_pkg::ST_ROUND: begin
            if (sts.round_last) state_in = uuid5_pkg::ST_FINAL;
         end
         uuid5_pkg::ST_FINAL: begin
            state_in = uuid5_pkg::ST_EMIT;
         end
         uuid5_pkg::ST_EMIT: begin
            if (rsp_ready && sts.char_last) state_in = uuid5_pkg::ST_IDLE;
         end
         default: state_in = uuid5_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath commands
   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         uuid5_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         uuid5_pkg::ST_ROUND: begin
            cmd.step = 1'b1;
         end
         uuid5_pkg::ST_FINAL: begin
            cmd.finish = 1'b1;
         end
         uuid5_pkg::ST_EMIT: begin
            rsp_valid   = 1'b1;
            cmd.advance = rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= uuid5_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/uuid5_dp.sv =====
// ---------------------------------------------------------------------------
// uuid5_dp
// Datapath: 16-word message schedule window, SHA-1 working registers with a
// single round unit, digest register with version/variant applied, and the
// character formatter that walks the digest nibbles.
// ---------------------------------------------------------------------------
module uuid5_dp (
   input  logic               clock,
   input  logic               reset,
   input  uuid5_pkg::cmd_type cmd,
   output uuid5_pkg::sts_type sts,
   input  logic [47:0]        mac_address,
   output logic [6:0]         text_char,
   output logic               last_char
);

   logic [31:0]  win_ff [16];
   logic [31:0]  win_in [16];
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]  a_in, b_in, c_in, d_in, e_in;
   logic [6:0]   round_ff, round_in;
   logic [5:0]   pos_ff, pos_in;
   logic [127:0] digest_ff, digest_in;

   logic [31:0]  f_val;
   logic [31:0]  k_val;
   logic [31:0]  t_val;
   logic [31:0]  w_new;
   logic [3:0]   nib_arr [32];
   logic [3:0]   cur_nib;

   // round function and constant by phase
   always_comb begin
      if (round_ff < 7'd20) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = uuid5_pkg::K0;
      end else if (round_ff < 7'd40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = uuid5_pkg::K1;
      end else if (round_ff < 7'd60) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = uuid5_pkg::K2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = uuid5_pkg::K3;
      end
      t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + win_ff[0];
      w_new = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
      w_new = {w_new[30:0], w_new[31]};
   end

   // next values of window, working registers, digest and counters
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         win_in[i] = win_ff[i];
      end
      a_in      = a_ff;
      b_in      = b_ff;
      c_in      = c_ff;
      d_in      = d_ff;
      e_in      = e_ff;
      round_in  = round_ff;
      pos_in    = pos_ff;
      digest_in = digest_ff;

      if (cmd.load) begin
         // build the single padded block
         win_in[0] = uuid5_pkg::NS_W0;
         win_in[1] = uuid5_pkg::NS_W1;
         win_in[2] = uuid5_pkg::NS_W2;
         win_in[3] = uuid5_pkg::NS_W3;
         win_in[4] = uuid5_pkg::hex_word(mac_address[47:32]);
         win_in[5] = uuid5_pkg::hex_word(mac_address[31:16]);
         win_in[6] = uuid5_pkg::hex_word(mac_address[15:0]);
         win_in[7] = uuid5_pkg::PAD_WORD;
         for (int i = 8; i < 15; i++) begin
            win_in[i] = '0;
         end
         win_in[15] = uuid5_pkg::LEN_WORD;
         a_in     = uuid5_pkg::H0;
         b_in     = uuid5_pkg::H1;
         c_in     = uuid5_pkg::H2;
         d_in     = uuid5_pkg::H3;
         e_in     = uuid5_pkg::H4;
         round_in = '0;
         pos_in   = '0;
      end else if (cmd.step) begin
         // advance schedule window by one word
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[15] = w_new;
         e_in     = d_ff;
         d_in     = c_ff;
         c_in     = {b_ff[1:0], b_ff[31:2]};
         b_in     = a_ff;
         a_in     = t_val;
         round_in = round_ff + 7'd1;
      end else if (cmd.finish) begin
         // keep first 16 digest bytes, force version and variant
         digest_in = {uuid5_pkg::H0 + a_ff, uuid5_pkg::H1 + b_ff,
                      uuid5_pkg::H2 + c_ff, uuid5_pkg::H3 + d_ff};
         digest_in[79:76] = uuid5_pkg::VERSION_NIB;
         digest_in[63:62] = uuid5_pkg::VARIANT_BITS;
      end else if (cmd.advance) begin
         pos_in = pos_ff + 6'd1;
      end
   end

   // counters
   always_ff @(posedge clock) begin
      if (reset) begin
         round_ff <= '0;
         pos_ff   <= '0;
      end else begin
         round_ff <= round_in;
         pos_ff   <= pos_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < 16; i++) begin
         win_ff[i] <= win_in[i];
      end
      a_ff      <= a_in;
      b_ff      <= b_in;
      c_ff      <= c_in;
      d_ff      <= d_in;
      e_ff      <= e_in;
      digest_ff <= digest_in;
   end

   // split digest into nibbles, first nibble most significant
   always_comb begin
      for (int i = 0; i < 32; i++) begin
         nib_arr[i] = digest_ff[127 - 4 * i -: 4];
      end
      cur_nib = nib_arr[uuid5_pkg::pos_nibble(pos_ff)];
   end

   // format current character
   assign text_char = uuid5_pkg::is_dash(pos_ff) ? uuid5_pkg::DASH_CHAR
                                                 : uuid5_pkg::nib_char(cur_nib);
   assign last_char = (pos_ff == uuid5_pkg::LAST_CHAR);

   assign sts.round_last = (round_ff == uuid5_pkg::LAST_ROUND);
   assign sts.char_last  = (pos_ff == uuid5_pkg::LAST_CHAR);

endmodule

// ===== rtl/uuid_v5_from_mac_unit.sv =====
// ---------------------------------------------------------------------------
// uuid_v5_from_mac_unit
// Name-based (version 5, SHA-1) UUID generator keyed by a 48-bit MAC.
// ---------------------------------------------------------------------------
// Input channel (req_): one word carries a MAC address, first byte in bits
// 47..40. The word is taken only while the unit is idle.
// Result channel (rsp_): 36 words per MAC, the UUID text in 8-4-4-4-12 form
// in lowercase ASCII with dashes; rsp_last_char marks the 36th word.
// Sequence: once the MAC is taken, the 80 SHA-1 rounds run through one
// shared round unit, a finalize step forms the digest, and then the
// characters are presented in order. No new MAC is taken before the last
// character of the previous UUID has gone.
// When the receiver stalls, the current character holds on the rsp_ ports
// and the unit waits; no MAC is taken until the last character is gone.
// Reset (synchronous, active high) returns the unit to idle with req_ready
// high and no result pending; a UUID in progress is dropped.
// ---------------------------------------------------------------------------
module uuid_v5_from_mac_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [47:0] req_mac_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_text_char,
   output logic        rsp_last_char
);

   uuid5_pkg::cmd_type cmd;
   uuid5_pkg::sts_type sts;

   uuid5_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   uuid5_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .mac_address (req_mac_address),
      .text_char   (rsp_text_char),
      .last_char   (rsp_last_char)
   );

endmodule

// ===== rtl/uuid5_check.sv =====
// ---------------------------------------------------------------------------
// uuid5_check
// Port-level checker for the UUID generator, bound to the top level.
// ---------------------------------------------------------------------------
module uuid5_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [47:0] req_mac_address,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [6:0]  rsp_text_char,
   input logic        rsp_last_char
);

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_text_char)
                                  && $stable(rsp_last_char))
      else $error("stalled result word changed");

   // never take a MAC while text is going out
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready while result pending");

   // a taken MAC starts hashing: no ready, no result next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mac_address == req_mac_address
      |=> !req_ready && !rsp_valid)
      else $error("unit not busy after taking a MAC");

   // last character sent returns the unit to idle
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_char |=> req_ready && !rsp_valid)
      else $error("unit not idle after last character");

   // only hex digits and dashes go out
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_text_char >= 7'h30 && rsp_text_char <= 7'h39)
                 || (rsp_text_char >= 7'h61 && rsp_text_char <= 7'h66)
                 || (rsp_text_char == 7'h2d))
      else $error("character outside UUID text set");

endmodule

bind uuid_v5_from_mac_unit uuid5_check u_uuid5_check (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_mac_address (req_mac_address),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_text_char   (rsp_text_char),
   .rsp_last_char   (rsp_last_char)
);

// ===== tb/tb_uuid_v5_from_mac_unit.sv =====
// ---------------------------------------------------------------------------
// tb_uuid_v5_from_mac_unit
// Self-checking bench for the MAC-keyed version 5 UUID generator. MAC words
// are pushed through a valid/ready request port. A behavioral SHA-1 model
// in the bench builds the 36 text characters each MAC must yield, and every
// response word is matched against them in order. Both ports idle at random
// in shifting proportions, with a final phase run at full rate.
// ---------------------------------------------------------------------------
module tb_uuid_v5_from_mac_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MACS_PER_PHASE = 134;
   localparam int STALL_LIMIT    = 4000;
   localparam int DRAIN_CYCLES   = 150;
   localparam int REPORT_LIMIT   = 10;

   // SHA-1 starting hash and round constants
   localparam logic [31:0] IV_A   = 32'h67452301;
   localparam logic [31:0] IV_B   = 32'hEFCDAB89;
   localparam logic [31:0] IV_C   = 32'h98BADCFE;
   localparam logic [31:0] IV_D   = 32'h10325476;
   localparam logic [31:0] IV_E   = 32'hC3D2E1F0;
   localparam logic [31:0] RC_CH  = 32'h5A827999;
   localparam logic [31:0] RC_P1  = 32'h6ED9EBA1;
   localparam logic [31:0] RC_MAJ = 32'h8F1BBCDC;
   localparam logic [31:0] RC_P2  = 32'hCA62C1D6;

   // DNS namespace UUID, padding marker and 224-bit length
   localparam logic [127:0] DNS_NAMESPACE = 128'h6ba7b8109dad11d180b400c04fd430c8;
   localparam logic [31:0]  PAD_MARK      = 32'h80000000;
   localparam logic [31:0]  MSG_BITS      = 32'h000000E0;

   localparam logic [3:0] UUID_VERSION = 4'h5;
   localparam logic [1:0] UUID_VARIANT = 2'b10;
   localparam logic [6:0] ASCII_ZERO   = 7'h30;
   localparam logic [6:0] ASCII_LOW_A  = 7'h61;
   localparam logic [6:0] ASCII_DASH   = 7'h2d;

   typedef struct packed {
      logic [6:0] text_char;
      logic       last_char;
   } uuid_char_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [47:0] req_mac_address = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [6:0]  rsp_text_char;
   logic        rsp_last_char;

   uuid_char_type pending_chars[$];
   uuid_char_type head_char;
   int          send_idle_pct = 22;
   int          recv_idle_pct = 66;
   int          fault_count   = 0;
   int          macs_sent     = 0;
   int          chars_checked = 0;
   int          stall_cycles  = 0;

   // Directed MACs: extremes, walking bits, digit/letter boundaries and the
   // multicast and locally administered flags. No digest is readable by eye,
   // so every row is checked against the SHA-1 model.
   logic [47:0] directed_mac [16] = '{
      48'h000000000000, 48'hffffffffffff, 48'h000000000001, 48'h800000000000,
      48'h0123456789ab, 48'hfedcba987654, 48'haaaaaaaaaaaa, 48'h555555555555,
      48'h00000000000a, 48'h999999999999, 48'ha0a0a0a0a0a0, 48'h0f0f0f0f0f0f,
      48'hf0f0f0f0f0f0, 48'h020000000000, 48'h010000000000, 48'h001b638445e6
   };

   uuid_v5_from_mac_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mac_address (req_mac_address),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_text_char   (rsp_text_char),
      .rsp_last_char   (rsp_last_char)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // lowercase hex digit for a nibble
   function automatic logic [6:0] hex_ascii(input logic [3:0] n);
      if (n < 4'd10) begin
         return ASCII_ZERO + 7'(n);
      end else begin
         return ASCII_LOW_A + 7'(n) - 7'd10;
      end
   endfunction

   function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
      return (x << s) | (x >> (32 - s));
   endfunction

   // Hash namespace + MAC text, stamp version/variant, queue the 36 characters
   function automatic void queue_uuid_text(input logic [47:0] mac);
      logic [31:0]  w [80];
      logic [31:0]  a, b, c, d, e, f, k, t;
      logic [127:0] digest;
      logic [7:0]   octet;
      int           i;

      // message block: namespace, 12 hex characters of the MAC, padding
      for (i = 0; i < 4; i++) begin
         w[i] = DNS_NAMESPACE[127 - 32 * i -: 32];
      end
      for (i = 4; i < 16; i++) begin
         w[i] = '0;
      end
      for (i = 0; i < 12; i++) begin
         w[4 + i / 4][31 - 8 * (i % 4) -: 8] = {1'b0, hex_ascii(mac[47 - 4 * i -: 4])};
      end
      w[7]  = PAD_MARK;
      w[15] = MSG_BITS;
      for (i = 16; i < 80; i++) begin
         w[i] = rotl(w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16], 1);
      end

      // eighty compression rounds
      a = IV_A; b = IV_B; c = IV_C; d = IV_D; e = IV_E;
      for (i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d);
            k = RC_CH;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = RC_P1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = RC_MAJ;
         end else begin
            f = b ^ c ^ d;
            k = RC_P2;
         end
         t = rotl(a, 5) + f + e + k + w[i];
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = t;
      end
      digest = {IV_A + a, IV_B + b, IV_C + c, IV_D + d};

      // version in byte 6 high nibble, variant in byte 8 top bits
      digest[79:76] = UUID_VERSION;
      digest[63:62] = UUID_VARIANT;

      // format 8-4-4-4-12 with dashes before bytes 4, 6, 8 and 10
      for (i = 0; i < 16; i++) begin
         if (i == 4 || i == 6 || i == 8 || i == 10) begin
            pending_chars.push_back('{text_char: ASCII_DASH, last_char: 1'b0});
         end
         octet = digest[127 - 8 * i -: 8];
         pending_chars.push_back('{text_char: hex_ascii(octet[7:4]), last_char: 1'b0});
         pending_chars.push_back('{text_char: hex_ascii(octet[3:0]), last_char: 1'b0});
      end
      pending_chars[pending_chars.size() - 1].last_char = 1'b1;
   endfunction

   // Random MAC: mostly full-range, some all-digit, all-letter, or a single bit set or cleared
   function automatic logic [47:0] random_mac();
      logic [47:0] mac;
      int          i;

      mac = {16'($urandom), $urandom};
      case ($urandom_range(9))
         0: begin
            for (i = 0; i < 12; i++) begin
               mac[4 * i +: 4] = 4'($urandom_range(9));
            end
         end
         1: begin
            for (i = 0; i < 12; i++) begin
               mac[4 * i +: 4] = 4'($urandom_range(15, 10));
            end
         end
         2: begin
            mac = 48'h1 << $urandom_range(47);
            if ($urandom_range(1) == 1) begin
               mac = ~mac;
            end
         end
         default: begin
         end
      endcase
      return mac;
   endfunction

   // Offer one MAC word after an optional random gap; queue its text on accept
   task automatic send_mac(input logic [47:0] mac);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(99) < send_idle_pct);
      end
      req_valid       <= 1'b1;
      req_mac_address <= mac;
      do begin
         @(posedge clock);
      end while (!req_ready);
      queue_uuid_text(mac);
      macs_sent++;
   endtask

   // Hold off the sender until every queued character has come out
   task automatic drain_uuid_text();
      req_valid <= 1'b0;
      while (pending_chars.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Match each response word against the oldest queued character
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_chars.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT) begin
               $display("%0t: unexpected word char=%h last=%b",
                        $realtime, rsp_text_char, rsp_last_char);
            end
         end else begin
            head_char = pending_chars.pop_front();
            chars_checked++;
            if (rsp_text_char !== head_char.text_char ||
                rsp_last_char !== head_char.last_char) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT) begin
                  $display("%0t: mismatch char exp=%h got=%h last exp=%b got=%b",
                           $realtime, head_char.text_char, rsp_text_char,
                           head_char.last_char, rsp_last_char);
               end
            end
         end
      end
   end

   // Watchdog: abort when neither port moves a word for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("tb_uuid_v5_from_mac_unit NOT OK");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table under the first idling mix
      foreach (directed_mac[i]) begin
         send_mac(directed_mac[i]);
      end
      drain_uuid_text();

      // random phases: sender-light/receiver-heavy, reversed, then full rate
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 22;
               recv_idle_pct = 66;
            end
            1: begin
               send_idle_pct = 66;
               recv_idle_pct = 22;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < MACS_PER_PHASE; n++) begin
            send_mac(random_mac());
         end
         drain_uuid_text();
      end

      // let any stray word surface before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Hashed %0d MACs (%0d directed) into %0d checked characters",
               macs_sent, $size(directed_mac), chars_checked);
      $display("under receiver-heavy, sender-heavy and full-rate handshake mixes");
      if (fault_count == 0 && pending_chars.size() == 0) begin
         $display("tb_uuid_v5_from_mac_unit OK");
      end else begin
         $display("%0d failures, %0d characters never arrived",
                  fault_count, pending_chars.size());
         $display("tb_uuid_v5_from_mac_unit NOT OK");
      end
      $finish;
   end

endmodule
